// File: rtl/core/tcrc_pkg.sv
// Shared types and constants of the text cell run coalescer.
// Holds the beat structs, command format and register indices; depends on nothing.

package tcrc_pkg;

   localparam int RUN_MAX_DEF = 32;
   localparam int CMD_DEPTH   = 2;
   localparam int OUT_DEPTH   = 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   localparam int PIX_W      = 20;
   localparam int GLYPH_W    = 21;

   localparam logic [CSR_IDX_W-1:0] REG_VIEW_START_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_END_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_START_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_END_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COMPARE_OLD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FONT_WIDTH   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FONT_HEIGHT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FONT_ASCENT  = 3'd7;

   localparam logic [11:0] RST_VIEW_START_X = 12'd0;
   localparam logic [12:0] RST_VIEW_END_X   = 13'd80;
   localparam logic [11:0] RST_VIEW_START_Y = 12'd0;
   localparam logic [12:0] RST_VIEW_END_Y   = 13'd25;
   localparam logic [7:0]  RST_FONT_WIDTH   = 8'd8;
   localparam logic [7:0]  RST_FONT_HEIGHT  = 8'd16;
   localparam logic [7:0]  RST_FONT_ASCENT  = 8'd12;

   typedef struct packed {
      logic [11:0]        cell_x;
      logic [11:0]        cell_y;
      logic [7:0]         new_color;
      logic [GLYPH_W-1:0] new_glyph;
      logic [7:0]         old_color;
      logic [GLYPH_W-1:0] old_glyph;
      logic               segment_end;
   } cell_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [7:0]         run_color;
      logic [GLYPH_W-1:0] glyph;
      logic [4:0]         glyph_index;
      logic               run_last;
   } result_type;

   typedef struct packed {
      logic               flush_pre;
      logic               append;
      logic               flush_post;
      logic [GLYPH_W-1:0] glyph;
      logic [7:0]         color;
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
   } cmd_type;

endpackage

// File: rtl/core/tcrc_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Generic over the item type; uses nothing from the package.

module tcrc_fifo #(
   parameter type ITEM_TYPE = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  ITEM_TYPE wr_item,
   input  logic     pop,
   output logic     empty,
   output ITEM_TYPE rd_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ITEM_TYPE         store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_item = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: rtl/core/tcrc_front.sv
// Front end: register file, cell intake, window and change classification, run origin.
// Tracks the run length and colour to decide flushes; depends on tcrc_pkg.

module tcrc_front #(
   parameter int RUN_MAX = tcrc_pkg::RUN_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  tcrc_pkg::cell_type               req_cell,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcrc_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                             cmd_push,
   input  logic                             cmd_full,
   output tcrc_pkg::cmd_type                cmd_item
);

   localparam int CNT_W = $clog2(RUN_MAX + 1);
   localparam int PW    = tcrc_pkg::PIX_W;

   logic [11:0] vsx_ff, vsy_ff;
   logic [12:0] vex_ff, vey_ff;
   logic        cmp_ff;
   logic [7:0]  fw_ff, fh_ff, fa_ff;

   tcrc_pkg::cell_type cell_ff;
   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]         col_ff, col_in;

   logic             in_win, same, pre, app, post, need, done, accept;
   logic [CNT_W-1:0] cnt_mid, cnt_app;
   logic [PW-1:0]    px, py;

   assign csr_ready = 1'b1;

   always_comb begin
      in_win = (cell_ff.cell_x >= vsx_ff) && ({1'b0, cell_ff.cell_x} < vex_ff) &&
               (cell_ff.cell_y >= vsy_ff) && ({1'b0, cell_ff.cell_y} < vey_ff);
      same   = cmp_ff && (cell_ff.new_color == cell_ff.old_color) &&
               (cell_ff.new_glyph == cell_ff.old_glyph);
      pre    = in_win && (cnt_ff != '0) &&
               ((cell_ff.new_color != col_ff) || same || (cnt_ff >= CNT_W'(RUN_MAX)));
      cnt_mid = pre ? '0 : cnt_ff;
      app     = in_win && !same;
      cnt_app = app ? cnt_mid + CNT_W'(1) : cnt_mid;
      post    = cell_ff.segment_end && (cnt_app != '0);
      need    = pre || app || post;
      done    = busy_ff && (!need || !cmd_full);
      px = PW'((PW'(cell_ff.cell_x) - PW'(vsx_ff)) * PW'(fw_ff));
      py = PW'((PW'(cell_ff.cell_y) - PW'(vsy_ff)) * PW'(fh_ff)) + PW'(fa_ff);
   end

   assign req_full = busy_ff && !done;
   assign accept   = req_push && !req_full;
   assign cmd_push = busy_ff && need && !cmd_full;

   always_comb begin
      cmd_item.flush_pre  = pre;
      cmd_item.append     = app;
      cmd_item.flush_post = post;
      cmd_item.glyph      = cell_ff.new_glyph;
      cmd_item.color      = cell_ff.new_color;
      cmd_item.pixel_x    = px;
      cmd_item.pixel_y    = py;
   end

   always_comb begin
      busy_in = done ? accept : (busy_ff || accept);
      cnt_in  = cnt_ff;
      col_in  = col_ff;
      if (done) begin
         cnt_in = post ? '0 : cnt_app;
         if (app && (cnt_mid == '0)) begin
            col_in = cell_ff.new_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         col_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         col_ff  <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cell_ff <= req_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vsx_ff <= tcrc_pkg::RST_VIEW_START_X;
         vex_ff <= tcrc_pkg::RST_VIEW_END_X;
         vsy_ff <= tcrc_pkg::RST_VIEW_START_Y;
         vey_ff <= tcrc_pkg::RST_VIEW_END_Y;
         cmp_ff <= 1'b0;
         fw_ff  <= tcrc_pkg::RST_FONT_WIDTH;
         fh_ff  <= tcrc_pkg::RST_FONT_HEIGHT;
         fa_ff  <= tcrc_pkg::RST_FONT_ASCENT;
      end else if (csr_valid) begin
         unique case (csr_index)
            tcrc_pkg::REG_VIEW_START_X: vsx_ff <= csr_data[11:0];
            tcrc_pkg::REG_VIEW_END_X:   vex_ff <= csr_data[12:0];
            tcrc_pkg::REG_VIEW_START_Y: vsy_ff <= csr_data[11:0];
            tcrc_pkg::REG_VIEW_END_Y:   vey_ff <= csr_data[12:0];
            tcrc_pkg::REG_COMPARE_OLD:  cmp_ff <= csr_data[0];
            tcrc_pkg::REG_FONT_WIDTH:   fw_ff  <= csr_data[7:0];
            tcrc_pkg::REG_FONT_HEIGHT:  fh_ff  <= csr_data[7:0];
            tcrc_pkg::REG_FONT_ASCENT:  fa_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/core/tcrc_back.sv
// Back end: run buffer memory, run state and the flush sequencer that emits glyph beats.
// Executes commands from the front queue; depends on tcrc_pkg.

module tcrc_back #(
   parameter int RUN_MAX = tcrc_pkg::RUN_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   output logic                 cmd_pop,
   input  tcrc_pkg::cmd_type    cmd_item,
   output logic                 out_push,
   input  logic                 out_full,
   output tcrc_pkg::result_type out_item
);

   localparam int CNT_W = $clog2(RUN_MAX + 1);
   localparam int IDX_W = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
   localparam int PW    = tcrc_pkg::PIX_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PRE  = 2'd1;
   localparam logic [1:0] ST_APP  = 2'd2;
   localparam logic [1:0] ST_POST = 2'd3;

   logic [tcrc_pkg::GLYPH_W-1:0] run_mem [RUN_MAX];

   logic [1:0]        state_ff, state_in;
   tcrc_pkg::cmd_type cmd_ff;
   logic [CNT_W-1:0]  iter_ff, iter_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        color_ff;
   logic [PW-1:0]     px_ff, py_ff;

   logic                 rd_valid_ff, rd_valid_in;
   tcrc_pkg::result_type rd_meta_ff;

   logic flushing, flush_end, issue, write_run, set_origin;

   assign flushing  = (state_ff == ST_PRE) || (state_ff == ST_POST);
   assign flush_end = flushing && (iter_ff == count_ff);
   assign out_push  = rd_valid_ff;
   assign issue     = flushing && (iter_ff != count_ff) && (!rd_valid_ff || !out_full);
   assign cmd_pop   = (state_ff == ST_IDLE) && !cmd_empty;
   assign write_run = (state_ff == ST_APP);
   assign set_origin = write_run && (count_ff == '0);

   always_comb begin
      out_item = rd_meta_ff;
   end

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      count_in    = count_ff;
      rd_valid_in = rd_valid_ff;
      if (issue) begin
         rd_valid_in = 1'b1;
         iter_in     = iter_ff + CNT_W'(1);
      end else if (!out_full) begin
         rd_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               priority if (cmd_item.flush_pre) state_in = ST_PRE;
               else if (cmd_item.append)        state_in = ST_APP;
               else if (cmd_item.flush_post)    state_in = ST_POST;
               else                             state_in = ST_IDLE;
            end
         end
         ST_PRE: begin
            if (flush_end) begin
               count_in = '0;
               iter_in  = '0;
               priority if (cmd_ff.append)   state_in = ST_APP;
               else if (cmd_ff.flush_post)   state_in = ST_POST;
               else                          state_in = ST_IDLE;
            end
         end
         ST_APP: begin
            count_in = count_ff + CNT_W'(1);
            state_in = cmd_ff.flush_post ? ST_POST : ST_IDLE;
         end
         ST_POST: begin
            if (flush_end) begin
               count_in = '0;
               iter_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         iter_ff     <= '0;
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
         color_ff    <= '0;
         px_ff       <= '0;
         py_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         iter_ff     <= iter_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
         if (set_origin) begin
            color_ff <= cmd_ff.color;
            px_ff    <= cmd_ff.pixel_x;
            py_ff    <= cmd_ff.pixel_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_item;
      end
   end

   always_ff @(posedge clock) begin
      if (write_run) begin
         run_mem[count_ff[IDX_W-1:0]] <= cmd_ff.glyph;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_meta_ff.glyph       <= run_mem[iter_ff[IDX_W-1:0]];
         rd_meta_ff.pixel_x     <= px_ff;
         rd_meta_ff.pixel_y     <= py_ff;
         rd_meta_ff.run_color   <= color_ff;
         rd_meta_ff.glyph_index <= 5'(iter_ff);
         rd_meta_ff.run_last    <= ((iter_ff + CNT_W'(1)) == count_ff);
      end
   end

endmodule

// File: rtl/core/text_cell_run_coalescer.sv
// Text cell run coalescer. A run's closing cell is registered in the front; its command
// crosses the command queue, the back registers it and goes from idle (via the append
// state if the cell is appended first) to a flush state, whose registered glyph read then
// crosses the result queue. The front takes one cell a cycle while the command queue has
// room; the back takes a command, appends, emits each beat and closes before the next one.
// Reset is synchronous: queues and run state empty, registers at defaults.

module text_cell_run_coalescer #(
   parameter int RUN_MAX = tcrc_pkg::RUN_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  tcrc_pkg::cell_type               req_cell,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output tcrc_pkg::result_type             rsp_result,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcrc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcrc_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                 fq_push, fq_full, fq_pop, fq_empty;
   tcrc_pkg::cmd_type    fq_wr, fq_rd;
   logic                 oq_push, oq_full;
   tcrc_pkg::result_type oq_wr;

   tcrc_front #(
      .RUN_MAX (RUN_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_cell  (req_cell),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_push  (fq_push),
      .cmd_full  (fq_full),
      .cmd_item  (fq_wr)
   );

   tcrc_fifo #(
      .ITEM_TYPE (tcrc_pkg::cmd_type),
      .DEPTH     (tcrc_pkg::CMD_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (fq_push),
      .full    (fq_full),
      .wr_item (fq_wr),
      .pop     (fq_pop),
      .empty   (fq_empty),
      .rd_item (fq_rd)
   );

   tcrc_back #(
      .RUN_MAX (RUN_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (fq_empty),
      .cmd_pop   (fq_pop),
      .cmd_item  (fq_rd),
      .out_push  (oq_push),
      .out_full  (oq_full),
      .out_item  (oq_wr)
   );

   tcrc_fifo #(
      .ITEM_TYPE (tcrc_pkg::result_type),
      .DEPTH     (tcrc_pkg::OUT_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (oq_push),
      .full    (oq_full),
      .wr_item (oq_wr),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_item (rsp_result)
   );

endmodule
